@@ rtl/core/hsd_pkg.sv @@
package hsd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PayloadW    = 32;
  localparam int unsigned PayBytes    = PayloadW / ByteW;
  localparam int unsigned FrameLenDef = 8;
  localparam int unsigned FrameLenMin = 7;
  localparam int unsigned FrameLenMax = 63;
  localparam int unsigned CmdOffset   = 1;
  localparam int unsigned PayOffset   = 2;

  typedef struct packed {
    logic [ByteW-1:0]    command;
    logic [PayloadW-1:0] payload;
  } hsd_res_t;

endpackage

@@ rtl/core/hsd_if.sv @@
interface hsd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [hsd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hsd_res_if;
  logic                         valid;
  logic                         ready;
  logic [hsd_pkg::ByteW-1:0]    command;
  logic [hsd_pkg::PayloadW-1:0] payload;

  modport source (output valid, output command, output payload, input ready);
  modport sink   (input valid, input command, input payload, output ready);
endinterface

interface hsd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hsd_pkg::ByteW-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/header_sum8_frame_deframer_unit.sv @@
// Fixed-length frame deframer with 8-bit additive checksum.
// rx_i carries one received byte per request. While hunting, bytes other than
// the header are dropped; a header byte opens a frame of FRAME_LEN bytes.
// Bytes 0..FRAME_LEN-3 are summed mod 256 and checked against the last byte;
// the byte at FRAME_LEN-2 is skipped by the sum. A good frame gives one
// request on res_o: command (offset 1) and payload (offsets 2..5, offset 2 in
// bits 7:0). A bad frame is dropped and hunting restarts at the next byte.
// cfg_i writes the header byte; it is always ready and is meant to be written
// while no frame is in flight.
// Throughput: one byte per cycle while rx_i.ready is high. The checksum byte
// is held in the input register; the result then goes to the result register,
// which drives res_o. When res_o stalls, the result register holds its request
// and bytes keep flowing until another result is due; then rx_i.ready drops.
// Reset clears the header to zero, empties both registers and starts hunting.
module header_sum8_frame_deframer_unit #(
  parameter int unsigned FRAME_LEN = hsd_pkg::FrameLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsd_cfg_if.sink    cfg_i,
  hsd_rx_if.sink     rx_i,
  hsd_res_if.source  res_o
);

  logic [hsd_pkg::ByteW-1:0] header_q;
  logic                      res_free;
  logic                      res_push;
  hsd_pkg::hsd_res_t         res_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
    end else if (cfg_i.valid) begin
      header_q <= cfg_i.data;
    end
  end

  hsd_frame_core #(
    .FrameLen (FRAME_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .header_i   (header_q),
    .res_free_i (res_free),
    .res_push_o (res_push),
    .res_o      (res_data)
  );

  hsd_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .free_o (res_free),
    .res_o  (res_o)
  );

  a_frame_len: assert property (@(posedge clk_i)
    (FRAME_LEN >= hsd_pkg::FrameLenMin) && (FRAME_LEN <= hsd_pkg::FrameLenMax))
    else $error("FRAME_LEN out of range");

  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |=> (header_q == $past(cfg_i.data)))
    else $error("header write not applied");

  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_o.valid)
    else $error("result valid right after reset");

endmodule

@@ rtl/core/hsd_frame_core.sv @@
module hsd_frame_core #(
  parameter int unsigned FrameLen = hsd_pkg::FrameLenDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hsd_rx_if.sink                     rx_i,
  input  logic [hsd_pkg::ByteW-1:0]  header_i,
  input  logic                       res_free_i,
  output logic                       res_push_o,
  output hsd_pkg::hsd_res_t          res_o
);

  localparam int unsigned PosW = $clog2(FrameLen);
  localparam logic [PosW-1:0] LastPos    = PosW'(FrameLen - 1);
  localparam logic [PosW-1:0] SumLastPos = PosW'(FrameLen - 3);
  localparam logic [PosW-1:0] CmdPos     = PosW'(hsd_pkg::CmdOffset);

  // input register
  logic                      in_valid_q, in_valid_d;
  logic [hsd_pkg::ByteW-1:0] in_byte_q;

  // frame state
  logic [PosW-1:0]              pos_q, pos_d;
  logic [hsd_pkg::ByteW-1:0]    sum_q, sum_d;
  logic [hsd_pkg::ByteW-1:0]    cmd_q, cmd_d;
  logic [hsd_pkg::PayloadW-1:0] pay_q, pay_d;

  logic at_last;
  logic sum_ok;
  logic produce;
  logic advance;

  assign at_last = (pos_q == LastPos);
  assign sum_ok  = (sum_q == in_byte_q);
  assign produce = in_valid_q && at_last && sum_ok;
  // a byte that yields a result waits until the result register has room
  assign advance = in_valid_q && (!produce || res_free_i);

  assign rx_i.ready = !in_valid_q || advance;

  assign res_push_o    = produce && advance;
  assign res_o.command = cmd_q;
  assign res_o.payload = pay_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_i.ready) begin
      in_valid_d = rx_i.valid;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    cmd_d = cmd_q;
    pay_d = pay_q;
    if (advance) begin
      if (pos_q == '0) begin
        if (in_byte_q == header_i) begin
          sum_d = in_byte_q;
          pos_d = PosW'(1);
        end
      end else if (at_last) begin
        pos_d = '0;
      end else begin
        if (pos_q <= SumLastPos) begin
          sum_d = sum_q + in_byte_q;
        end
        if (pos_q == CmdPos) begin
          cmd_d = in_byte_q;
        end
        for (int k = 0; k < hsd_pkg::PayBytes; k++) begin
          if (pos_q == PosW'(hsd_pkg::PayOffset + k)) begin
            pay_d[k*hsd_pkg::ByteW +: hsd_pkg::ByteW] = in_byte_q;
          end
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
      cmd_q      <= '0;
      pay_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      cmd_q      <= cmd_d;
      pay_q      <= pay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("frame position beyond last byte");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled byte lost from input register");

  a_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && at_last) |=> (pos_q == '0))
    else $error("no return to hunting after checksum byte");

  a_drop_non_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pos_q == '0 && in_byte_q != header_i) |=> (pos_q == '0))
    else $error("frame started on a non-header byte");

endmodule

@@ rtl/core/hsd_out_reg.sv @@
module hsd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsd_pkg::hsd_res_t data_i,
  output logic              free_o,
  hsd_res_if.source         res_o
);

  logic              valid_q, valid_d;
  hsd_pkg::hsd_res_t data_q;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.command = data_q.command;
  assign res_o.payload = data_q.payload;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o)
    else $error("result register overwritten before it was taken");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_o.ready) |=> (valid_q && $stable(data_q)))
    else $error("pending result changed while stalled");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> valid_q)
    else $error("pushed result not presented");

endmodule
